/* rtl/sem_pkg.sv */
// ---------------------------------------------------------------------------
// sem_pkg - shared types and constants of the Sobel edge magnitude block
// Field widths, register indexes, controller states and the command and
// status words between controller and datapath.
// ---------------------------------------------------------------------------
package sem_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned PIX_W       = 3 * CHAN_W;
  localparam int unsigned WIDTH_REG_W = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned GRAD_W      = 12;
  localparam int unsigned SUMSQ_W     = 2 * GRAD_W + 1;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CHAN_W-1:0]       MAG_MAX      = 8'd255;
  localparam logic [SUMSQ_W-1:0]      SAT_LIMIT    = 25'd65280;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_GRAD   = 7'b0000100,
    ST_SQUARE = 7'b0001000,
    ST_ROOT   = 7'b0010000,
    ST_FINISH = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  typedef struct packed {
    logic take;
    logic load;
    logic grad;
    logic square;
    logic root_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic root_last;
    logic counters_zero;
  } status_t;

endpackage

/* rtl/sem_pix_if.sv */
// ---------------------------------------------------------------------------
// sem_pix_if - pixel input channel
// Valid/ready channel carrying one RGB pixel or a flush word.
// ---------------------------------------------------------------------------
interface sem_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       flush;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, flush, input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, flush, output ready);
endinterface

/* rtl/sem_edge_if.sv */
// ---------------------------------------------------------------------------
// sem_edge_if - edge result channel
// Valid/ready channel carrying one RGB gradient magnitude word.
// ---------------------------------------------------------------------------
interface sem_edge_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_red;
  logic [7:0] edge_green;
  logic [7:0] edge_blue;
  logic       frame_end;

  modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

/* rtl/sem_ctrl.sv */
// ---------------------------------------------------------------------------
// sem_ctrl - sequencing controller
// One-hot state machine stepping one word through load, gradient, square,
// root and output.
// ---------------------------------------------------------------------------
module sem_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  sem_pkg::status_t status,
  output sem_pkg::cmd_t    cmd,
  output logic             in_ready,
  output logic             out_valid
);

  sem_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sem_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      sem_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (!status.drop) state_next = sem_pkg::ST_LOAD;
        end
      end
      sem_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        state_next = status.emit ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
      end
      sem_pkg::ST_GRAD: begin
        cmd.grad = 1'b1;
        state_next = sem_pkg::ST_SQUARE;
      end
      sem_pkg::ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = sem_pkg::ST_ROOT;
      end
      sem_pkg::ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_next = sem_pkg::ST_FINISH;
      end
      sem_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = sem_pkg::ST_OUT;
      end
      sem_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = sem_pkg::ST_IDLE;
      end
      default: begin
        state_next = sem_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sem_datapath.sv */
// ---------------------------------------------------------------------------
// sem_datapath - line stores, window, counters and magnitude arithmetic
// Two line memories, the 3x3 window, frame position counters, per-channel
// Sobel sums, squares and a bit-serial rounded square root.
// ---------------------------------------------------------------------------
module sem_datapath #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sem_pkg::cmd_t                     cmd,
  output sem_pkg::status_t                  status,
  input  logic [sem_pkg::CHAN_W-1:0]        pixel_red,
  input  logic [sem_pkg::CHAN_W-1:0]        pixel_green,
  input  logic [sem_pkg::CHAN_W-1:0]        pixel_blue,
  input  logic                              flush,
  input  logic                              cfg_write,
  input  logic [sem_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [sem_pkg::CHAN_W-1:0]        edge_red,
  output logic [sem_pkg::CHAN_W-1:0]        edge_green,
  output logic [sem_pkg::CHAN_W-1:0]        edge_blue,
  output logic                              frame_end
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned CW = sem_pkg::CHAN_W;
  localparam int unsigned GW = sem_pkg::GRAD_W;
  localparam int unsigned SW = sem_pkg::SUMSQ_W;

  logic [sem_pkg::WIDTH_REG_W-1:0]  width_reg;
  logic [sem_pkg::HEIGHT_REG_W-1:0] height_reg;
  logic [WW-1:0] w_act;
  logic [HW-1:0] h_act;

  logic [AW-1:0] in_col, out_col;
  logic [HW-1:0] in_row, out_row;
  logic [WW-1:0] in_col_inc, out_col_inc;
  logic [HW-1:0] out_row_inc;

  logic [sem_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0] upper_rd, middle_rd;
  logic [sem_pkg::PIX_W-1:0] pix;
  logic [sem_pkg::PIX_W-1:0] win [9];

  logic signed [GW-1:0] gx [3];
  logic signed [GW-1:0] gy [3];
  logic [SW-1:0]        sumsq [3];
  logic [CW-1:0]        root [3];
  logic [2:0]           bit_cnt;
  logic                 last_pix;

  // Clamp configured size into the supported range.
  always_comb begin
    if (width_reg == '0) w_act = WW'(1);
    else if (32'(width_reg) > 32'(MAX_WIDTH)) w_act = WW'(MAX_WIDTH);
    else w_act = WW'(width_reg);
    if (height_reg == '0) h_act = HW'(1);
    else if (32'(height_reg) > 32'(MAX_HEIGHT)) h_act = HW'(MAX_HEIGHT);
    else h_act = HW'(height_reg);
  end

  assign in_col_inc  = WW'(in_col) + WW'(1);
  assign out_col_inc = WW'(out_col) + WW'(1);
  assign out_row_inc = out_row + HW'(1);
  assign last_pix    = (out_row_inc >= h_act) && (out_col_inc >= w_act);

  assign status.drop          = flush && (in_row < h_act);
  assign status.emit          = !((in_row == '0) || ((in_row == HW'(1)) && (in_col == '0)));
  assign status.root_last     = (bit_cnt == '0);
  assign status.counters_zero = (in_col == '0) && (in_row == '0) &&
                                (out_col == '0) && (out_row == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= sem_pkg::WIDTH_RESET;
      height_reg <= sem_pkg::HEIGHT_RESET;
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (cfg_write) begin
      if (cfg_index == sem_pkg::CFG_WIDTH) begin
        width_reg <= cfg_data[sem_pkg::WIDTH_REG_W-1:0];
      end else begin
        height_reg <= cfg_data;
      end
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (cmd.load) begin
        if (in_col_inc >= w_act) begin
          in_col <= '0;
          in_row <= in_row + HW'(1);
        end else begin
          in_col <= in_col_inc[AW-1:0];
        end
      end
      if (cmd.finish) begin
        if (last_pix) begin
          in_col  <= '0;
          in_row  <= '0;
          out_col <= '0;
          out_row <= '0;
        end else if (out_col_inc >= w_act) begin
          out_col <= '0;
          out_row <= out_row_inc;
        end else begin
          out_col <= out_col_inc[AW-1:0];
        end
      end
    end
  end

  // Capture the word; drain positions carry no pixel.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix <= (in_row < h_act) ? {pixel_blue, pixel_green, pixel_red} : '0;
    end
  end

  // Line stores: read every cycle at the input column, write on load.
  always_ff @(posedge clk) begin
    upper_rd  <= upper_mem[in_col];
    middle_rd <= middle_mem[in_col];
    if (cmd.load) begin
      upper_mem[in_col]  <= middle_rd;
      middle_mem[in_col] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else if (cmd.load) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= upper_rd;
      win[5] <= middle_rd;
      win[8] <= pix;
    end
  end

  // Gradient, squares and root, one channel per lane.
  logic top_ok, bot_ok, left_ok, right_ok;
  logic [8:0] use_tap;
  assign top_ok   = (out_row != '0);
  assign bot_ok   = (out_row_inc < h_act);
  assign left_ok  = (out_col != '0);
  assign right_ok = (out_col_inc < w_act);
  assign use_tap = {bot_ok & right_ok, bot_ok, bot_ok & left_ok,
                    right_ok, 1'b1, left_ok,
                    top_ok & right_ok, top_ok, top_ok & left_ok};

  logic [CW-1:0] trial [3];
  logic [CW-1:0] bit_mask;
  assign bit_mask = CW'(1) << bit_cnt;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic signed [GW-1:0] v [9];
    logic [2*CW-1:0]      trial_sq, root_sq;
    logic [SW-1:0]        resid;
    always_comb begin
      for (int i = 0; i < 9; i++) begin
        v[i] = use_tap[i] ? GW'({1'b0, win[i][c*CW +: CW]}) : '0;
      end
      trial[c] = root[c] | bit_mask;
    end
    assign trial_sq = trial[c] * trial[c];
    assign root_sq  = root[c] * root[c];
    assign resid    = sumsq[c] - SW'(root_sq);

    always_ff @(posedge clk) begin
      if (cmd.grad) begin
        gx[c] <= GW'(v[2] - v[0] + 2 * (v[5] - v[3]) + v[8] - v[6]);
        gy[c] <= GW'(v[6] - v[0] + 2 * (v[7] - v[1]) + v[8] - v[2]);
      end
      if (cmd.square) begin
        sumsq[c] <= SW'(gx[c] * gx[c]) + SW'(gy[c] * gy[c]);
        root[c]  <= '0;
      end else if (cmd.root_step) begin
        if (SW'(trial_sq) <= sumsq[c]) root[c] <= trial[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.square) bit_cnt <= 3'd7;
    else if (cmd.root_step) bit_cnt <= bit_cnt - 3'd1;
  end

  // Round to nearest, saturate.
  function automatic logic [CW-1:0] round_sat(input logic [SW-1:0] s,
                                               input logic [CW-1:0] n,
                                               input logic [SW-1:0] r);
    logic [CW-1:0] res;
    if (s > sem_pkg::SAT_LIMIT) res = sem_pkg::MAG_MAX;
    else if (r > SW'(n) && n != sem_pkg::MAG_MAX) res = n + CW'(1);
    else res = n;
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      edge_red   <= round_sat(sumsq[0], root[0], g_lane[0].resid);
      edge_green <= round_sat(sumsq[1], root[1], g_lane[1].resid);
      edge_blue  <= round_sat(sumsq[2], root[2], g_lane[2].resid);
      frame_end  <= last_pix;
    end
  end

endmodule

/* rtl/sobel_edge_magnitude_rgb.sv */
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb - streaming 3x3 Sobel edge magnitude, RGB
// Top level joining the sequencing controller and the datapath.
// ---------------------------------------------------------------------------
// Pixels enter in raster order, one word at a time; each word is handled to
// completion before the next is taken. A flush word inside the frame is
// dropped; a word that yields no result (the first row plus one pixel) only
// loads the line stores and window; a word that yields a result then runs the
// gradient, square, 8-step bit-serial square root, rounding and output steps
// and waits out any output stall. Results lag input by one row plus one pixel;
// after the last pixel send frame_width + 1 flush words to drain the frame.
// Out-of-frame neighbors count as zero. Writing a register abandons the frame
// in progress. Line stores need no clearing after reset.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
  parameter int unsigned MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sem_pix_if.sink                        pix_in,
  sem_edge_if.source                     edge_out,
  input  logic                           cfg_write,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

  sem_pkg::cmd_t    cmd;
  sem_pkg::status_t status;

  // Controller: hold one word at a time, advance through the steps.
  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix_in.valid),
    .out_ready (edge_out.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (pix_in.ready),
    .out_valid (edge_out.valid)
  );

  // Datapath: line stores, window, counters and arithmetic.
  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .pixel_red   (pix_in.pixel_red),
    .pixel_green (pix_in.pixel_green),
    .pixel_blue  (pix_in.pixel_blue),
    .flush       (pix_in.flush),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .edge_red    (edge_out.edge_red),
    .edge_green  (edge_out.edge_green),
    .edge_blue   (edge_out.edge_blue),
    .frame_end   (edge_out.frame_end)
  );

`ifndef SYNTHESIS
  // One word in flight: never take input while a result is shown.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(pix_in.ready && edge_out.valid))
    else $error("input taken while result pending");

  // A register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> status.counters_zero)
    else $error("counters not cleared by register write");

  // The frame's last result leaves the counters at the frame start.
  a_frame_end_restart: assert property (@(posedge clk) disable iff (rst)
    (edge_out.valid && edge_out.frame_end) |-> status.counters_zero)
    else $error("counters not cleared after frame end");

  // A dropped flush word keeps the block ready.
  a_drop_ready: assert property (@(posedge clk) disable iff (rst)
    (pix_in.valid && pix_in.ready && status.drop && !cfg_write) |=> pix_in.ready)
    else $error("dropped flush word stalled the input");
`endif

endmodule

/* sim/sobel_edge_magnitude_rgb_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_tb - self-checking bench for the RGB Sobel block
// Streams small frames through the block. A line-buffer predictor keeps its
// own window and counters and queues the expected edge words. Each result is
// checked in order against that queue.
// ---------------------------------------------------------------------------
module sobel_edge_magnitude_rgb_tb;

  localparam int unsigned WIN_MAX   = 1024;
  localparam int unsigned HGT_MAX   = 4096;
  localparam int unsigned ITEM_GOAL = 1950;
  // Longest quiet stretch: the long output hold-off plus one word's work.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 24;

  typedef struct packed {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       flush;
  } pix_word_t;

  typedef struct packed {
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit       frame_end;
  } edge_word_t;

  // Predict edge words from accepted pixel words; check results in order.
  class edge_magnitude_tracker;
    bit [10:0]   width_reg = sem_pkg::WIDTH_RESET;
    bit [12:0]   height_reg = sem_pkg::HEIGHT_RESET;
    bit [23:0]   upper_line[WIN_MAX];
    bit [23:0]   middle_line[WIN_MAX];
    bit [23:0]   win[9];
    int unsigned in_col, in_row, out_col, out_row;
    edge_word_t  pending_edges[$];
    int unsigned mismatches;

    function void clear_counters();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    endfunction

    function void write_reg(sem_pkg::cfg_idx_t idx, bit [12:0] value);
      if (idx == sem_pkg::CFG_WIDTH) width_reg = value[10:0];
      else height_reg = value;
      clear_counters();
    endfunction

    function int unsigned eff_width();
      if (width_reg < 1) return 1;
      if (width_reg > WIN_MAX) return WIN_MAX;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < 1) return 1;
      if (height_reg > HGT_MAX) return HGT_MAX;
      return height_reg;
    endfunction

    // Round-to-nearest integer square root, saturating at 255.
    function bit [7:0] rounded_root(int unsigned s);
      int unsigned n;
      n = 0;
      if (s > 65280) return 8'd255;
      for (int unsigned b = 128; b != 0; b = b >> 1)
        if ((n | b) * (n | b) <= s) n = n | b;
      if (s - n * n > n) n++;
      return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function void note_pixel_word(pix_word_t p);
      int unsigned w, h, k, col;
      bit [23:0]   pix;
      int          sx, sy, rr, cc, v;
      int          kx[9], ky[9];
      edge_word_t  e;
      bit [7:0]    mag[3];
      w = eff_width();
      h = eff_height();
      k = in_row * w + in_col;
      pix = '0;
      col = in_col;
      kx = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
      ky = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};
      if (k < h * w) begin
        // drop flush words inside the frame
        if (p.flush) return;
        pix = {p.blue, p.green, p.red};
      end
      if (col >= WIN_MAX) col = WIN_MAX - 1;
      for (int r = 0; r < 3; r++) begin
        win[r*3]   = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[2] = upper_line[col];
      win[5] = middle_line[col];
      win[8] = pix;
      upper_line[col]  = middle_line[col];
      middle_line[col] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (k < w + 1) return;
      for (int ch = 0; ch < 3; ch++) begin
        sx = 0;
        sy = 0;
        for (int i = 0; i < 9; i++) begin
          rr = int'(out_row) + i / 3 - 1;
          cc = int'(out_col) + i % 3 - 1;
          if (rr < 0 || cc < 0 || rr >= int'(h) || cc >= int'(w)) continue;
          v = (win[i] >> (8 * ch)) & 8'hFF;
          sx += v * kx[i];
          sy += v * ky[i];
        end
        mag[ch] = rounded_root(sx * sx + sy * sy);
      end
      e.red = mag[0];
      e.green = mag[1];
      e.blue = mag[2];
      if (out_row + 1 >= h && out_col + 1 >= w) begin
        e.frame_end = 1'b1;
        clear_counters();
      end else begin
        e.frame_end = 1'b0;
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
      pending_edges.push_back(e);
    endfunction

    function void check_edge_word(edge_word_t got);
      edge_word_t exp;
      if (pending_edges.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected edge word %h", got);
        return;
      end
      exp = pending_edges.pop_front();
      if (got.red != exp.red || got.green != exp.green || got.blue != exp.blue ||
          got.frame_end != exp.frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("edge mismatch: expected r%0d g%0d b%0d end%0d, got r%0d g%0d b%0d end%0d",
                   exp.red, exp.green, exp.blue, exp.frame_end,
                   got.red, got.green, got.blue, got.frame_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write;
  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data;

  sem_pix_if  pix_ch ();
  sem_edge_if edge_ch ();

  sobel_edge_magnitude_rgb i_dut (
    .clk      (clk),
    .rst      (rst),
    .pix_in   (pix_ch),
    .edge_out (edge_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  edge_magnitude_tracker tracker = new();

  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned quiet_cycles;
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: stall on segments of random mode; honor a long hold-off on request.
  initial begin : receiver
    int unsigned seg_left, mode, hold_left;
    edge_ch.ready <= 1'b0;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        mode = $urandom_range(0, 2);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        edge_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: edge_ch.ready <= 1'b1;
          1: edge_ch.ready <= ($urandom_range(0, 9) < 7);
          default: edge_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Check every accepted edge word.
  always @(posedge clk) begin
    if (!rst && edge_ch.valid && edge_ch.ready)
      tracker.check_edge_word({edge_ch.edge_red, edge_ch.edge_green,
                               edge_ch.edge_blue, edge_ch.frame_end});
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (edge_ch.valid && edge_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word; open a gap first when the burst is used up.
  task automatic send_word(input pix_word_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_red   <= p.red;
    pix_ch.pixel_green <= p.green;
    pix_ch.pixel_blue  <= p.blue;
    pix_ch.flush       <= p.flush;
    do @(posedge clk); while (!(pix_ch.valid && pix_ch.ready));
    tracker.note_pixel_word(p);
    burst_left--;
  endtask

  // Hold until every expected word has arrived, then let the block settle.
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write both registers back to back; the block is idle here.
  task automatic program_frame(input bit [12:0] w, input bit [12:0] h);
    cfg_write <= 1'b1;
    cfg_index <= sem_pkg::CFG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    tracker.write_reg(sem_pkg::CFG_WIDTH, w);
    cfg_index <= sem_pkg::CFG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    tracker.write_reg(sem_pkg::CFG_HEIGHT, h);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_word_t rand_pixel(bit flush);
    pix_word_t p;
    p.red = rand_chan();
    p.green = rand_chan();
    p.blue = rand_chan();
    p.flush = flush;
    return p;
  endfunction

  // Stream one frame and its drain. Stop after pixel_cap pixels to abandon it.
  task automatic run_frame(input int unsigned noise_pct, input int unsigned drain_pix_pct,
                           input int unsigned pixel_cap);
    int unsigned w, h;
    w = tracker.eff_width();
    h = tracker.eff_height();
    for (int unsigned k = 0; k < h * w && k < pixel_cap; k++) begin
      if ($urandom_range(0, 99) < noise_pct) send_word(rand_pixel(1'b1));
      send_word(rand_pixel(1'b0));
      words_sent++;
    end
    if (pixel_cap >= h * w) begin
      for (int unsigned d = 0; d <= w; d++) begin
        send_word(rand_pixel($urandom_range(0, 99) >= drain_pix_pct));
        words_sent++;
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    pix_word_t p;
    int unsigned w, h;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= sem_pkg::CFG_WIDTH;
    cfg_data <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel_red <= '0;
    pix_ch.pixel_green <= '0;
    pix_ch.pixel_blue <= '0;
    pix_ch.flush <= 1'b0;
    burst_left = 0;
    words_sent = 0;
    hold_request = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: a few pixels, then abandon by reprogramming.
    run_frame(10, 0, 8);

    // 3x3 frame: all-ones checkerboard extremes, a flush mid-frame, pixels in drain.
    program_frame(13'd3, 13'd3);
    for (int unsigned k = 0; k < 9; k++) begin
      p = (k % 2) ? pix_word_t'{8'd255, 8'd255, 8'd255, 1'b0}
                  : pix_word_t'{8'd0, 8'd0, 8'd0, 1'b0};
      if (k == 4) send_word('{8'd255, 8'd255, 8'd255, 1'b1});
      send_word(p);
    end
    send_word('{8'd255, 8'd0, 8'd255, 1'b0});
    send_word('{8'd0, 8'd0, 8'd0, 1'b1});
    send_word('{8'd0, 8'd255, 8'd0, 1'b0});
    send_word('{8'd0, 8'd0, 8'd0, 1'b1});
    wait_drained();

    // Zero width and height clamp to a single pixel.
    program_frame(13'd0, 13'd0);
    run_frame(30, 50, '1);

    // Widest row (clamped from the top of the register) in a one-row frame.
    program_frame(13'd2047, 13'd1);
    run_frame(2, 30, '1);

    // Tallest frame (clamped), one column wide; abandon part way.
    program_frame(13'd1, 13'd8191);
    run_frame(5, 0, 40);

    // Exact upper bounds, abandoned within the first row.
    program_frame(13'd1024, 13'd4096);
    run_frame(0, 0, 20);

    // Fill the block while the output side holds off for a long stretch.
    program_frame(13'd4, 13'd4);
    hold_request = 500;
    run_frame(0, 20, '1);

    // Random frames: mostly complete, some abandoned, some noisy.
    while (words_sent < ITEM_GOAL) begin
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      program_frame(13'(w), 13'(h));
      if ($urandom_range(0, 9) == 0)
        run_frame($urandom_range(0, 20), $urandom_range(0, 100), $urandom_range(1, w * h));
      else
        run_frame($urandom_range(0, 3) == 0 ? $urandom_range(5, 30) : 0,
                  $urandom_range(0, 100), '1);
    end

    wait_drained();
    if (tracker.mismatches == 0 && tracker.pending_edges.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
